@@ sv/sptmm_pkg.sv @@
// Shared types and constants for the scratchpad temperature min/max block.
// No dependencies; every other file depends on this package.
package sptmm_pkg;

    localparam int MODE_W   = 2;
    localparam int SENSOR_W = 2;
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int TENTHS_W = 12;
    localparam int FP_W     = 15;

    localparam logic [MODE_W-1:0] MODE_BYTE   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RESET  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ABSENT = 2'd2;

    // Scratchpad byte positions
    localparam logic [POS_W-1:0] POS_TEMP_LSB     = 4'd0;
    localparam logic [POS_W-1:0] POS_TEMP_MSB     = 4'd1;
    localparam logic [POS_W-1:0] POS_COUNT_REMAIN = 4'd6;
    localparam logic [POS_W-1:0] POS_COUNT_PER_C  = 4'd7;
    localparam logic [POS_W-1:0] POS_CRC          = 4'd8;

    localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h8C;
    localparam logic [15:0]       QUARTER_DEG = 16'h0040;

    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [6:0]                 PCT_SCALE    = 7'd100;
    localparam logic signed [TENTHS_W-1:0] TEN_SCALE    = 12'sd10;
    localparam logic [7:0]                 TENTH_RECIP  = 8'd205;
    localparam int                         RECIP_SHIFT  = 11;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_CONVERT,
        KIND_PLAIN
    } kind_t;

    typedef struct packed {
        logic accept;
        logic div_step;
        logic mul;
        logic sum;
        logic apply;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  out_free;
    } dp_stat_t;

endpackage

@@ sv/sptmm_ifs.sv @@
// Handshake channels for the scratchpad block: request items in, result items out.
// Depends on sptmm_pkg for field widths.
interface sptmm_req_if;
    logic                              valid;
    logic                              ready;
    logic [sptmm_pkg::MODE_W-1:0]      mode;
    logic [sptmm_pkg::SENSOR_W-1:0]    sensor;
    logic [sptmm_pkg::BYTE_W-1:0]      data_byte;

    modport source (output valid, output mode, output sensor, output data_byte, input ready);
    modport sink   (input valid, input mode, input sensor, input data_byte, output ready);
endinterface

interface sptmm_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [sptmm_pkg::SENSOR_W-1:0]       sensor_out;
    logic                                 crc_ok;
    logic signed [sptmm_pkg::TENTHS_W-1:0] current_tenths;
    logic                                 current_valid;
    logic signed [sptmm_pkg::TENTHS_W-1:0] minimum_tenths;
    logic signed [sptmm_pkg::TENTHS_W-1:0] maximum_tenths;
    logic                                 minmax_valid;

    modport source (output valid, output sensor_out, output crc_ok, output current_tenths,
                    output current_valid, output minimum_tenths, output maximum_tenths,
                    output minmax_valid, input ready);
    modport sink   (input valid, input sensor_out, input crc_ok, input current_tenths,
                    input current_valid, input minimum_tenths, input maximum_tenths,
                    input minmax_valid, output ready);
endinterface

@@ sv/scratchpad_temperature_minmax_top.sv @@
// Scratchpad temperature min/max: top level joining sequencer and datapath.
// Scratchpad bytes 0-7 are accepted while the sequencer is idle and give no item. The
// ninth byte with a good CRC runs a 16-step serial divider, two conversion steps and a
// store update; other result-producing items go straight to the store update. The divider
// sets the long path; the result register lets the next item enter while a result waits.
// Asynchronous active-low reset clears frame state and every sensor's readings at once.
module scratchpad_temperature_minmax_top #(
    parameter int SENSOR_COUNT = 3
) (
    input logic        clk,
    input logic        rst_n,
    sptmm_req_if.sink  req,
    sptmm_rsp_if.source rsp
);
    import sptmm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    sptmm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .cmd      (cmd),
        .stat     (stat)
    );

    sptmm_dp #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode           (req.mode),
        .sensor         (req.sensor),
        .data_byte      (req.data_byte),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (rsp.valid),
        .out_ready      (rsp.ready),
        .sensor_out     (rsp.sensor_out),
        .crc_ok         (rsp.crc_ok),
        .current_tenths (rsp.current_tenths),
        .current_valid  (rsp.current_valid),
        .minimum_tenths (rsp.minimum_tenths),
        .maximum_tenths (rsp.maximum_tenths),
        .minmax_valid   (rsp.minmax_valid)
    );

endmodule

@@ sv/sptmm_ctrl.sv @@
// Sequencer for the scratchpad block: accepts items, runs the divide/convert steps,
// and hands results to the output register. Depends on sptmm_pkg.
module sptmm_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output sptmm_pkg::dp_cmd_t   cmd,
    input  sptmm_pkg::dp_stat_t  stat
);
    import sptmm_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_SUM,
        ST_APPLY,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.accept   = in_valid && in_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    case (stat.kind)
                        KIND_CONVERT:
                        begin
                            state_next = ST_DIV;
                            cnt_next   = DIV_CNT_W'(DIV_STEPS - 1);
                        end
                        KIND_PLAIN: state_next = ST_APPLY;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                    state_next = ST_MUL;
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                cmd.apply  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register can take the item
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.accept)
        else $error("item accepted while busy");

    a_convert_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && stat.kind == KIND_CONVERT) |=> (state_reg == ST_DIV))
        else $error("conversion did not start the divider");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("output loaded while occupied");

    a_emit_follows_apply: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.apply |=> (state_reg == ST_EMIT))
        else $error("apply not followed by emit");

endmodule

@@ sv/sptmm_dp.sv @@
// Datapath for the scratchpad block: CRC, byte capture, serial divider, tenths
// conversion, per-sensor store and output register. Depends on sptmm_pkg.
module sptmm_dp #(
    parameter int SENSOR_COUNT = 3
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic [sptmm_pkg::MODE_W-1:0]         mode,
    input  logic [sptmm_pkg::SENSOR_W-1:0]       sensor,
    input  logic [sptmm_pkg::BYTE_W-1:0]         data_byte,
    input  sptmm_pkg::dp_cmd_t                   cmd,
    output sptmm_pkg::dp_stat_t                  stat,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sptmm_pkg::SENSOR_W-1:0]       sensor_out,
    output logic                                 crc_ok,
    output logic signed [sptmm_pkg::TENTHS_W-1:0] current_tenths,
    output logic                                 current_valid,
    output logic signed [sptmm_pkg::TENTHS_W-1:0] minimum_tenths,
    output logic signed [sptmm_pkg::TENTHS_W-1:0] maximum_tenths,
    output logic                                 minmax_valid
);
    import sptmm_pkg::*;

    localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_CONVERT,
        OP_RESET,
        OP_ABSENT
    } op_t;

    function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] c;
        c = crc ^ d;
        for (int b = 0; b < BYTE_W; b++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // frame state
    logic [BYTE_W-1:0] crc_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [BYTE_W-1:0] raw_low_reg, raw_high_reg, cnt_rem_reg, cpd_reg;

    // item in flight
    logic [SENSOR_W-1:0] item_sensor_reg;
    op_t                 op_reg;
    logic [15:0]         num_reg;
    logic [BYTE_W-1:0]   rem_reg;
    logic                neg_reg;
    logic signed [TENTHS_W-1:0] whole10_reg, reading_reg;
    logic [FP_W-1:0]     fp_reg;

    // per-sensor store
    logic signed [TENTHS_W-1:0] cur_reg [SENSOR_COUNT];
    logic signed [TENTHS_W-1:0] min_reg [SENSOR_COUNT];
    logic signed [TENTHS_W-1:0] max_reg [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0]    pres_reg, ext_reg;

    // output register
    logic                       out_valid_reg;
    logic [SENSOR_W-1:0]        out_sensor_reg;
    logic                       out_ok_reg, out_cur_valid_reg, out_mm_valid_reg;
    logic signed [TENTHS_W-1:0] out_cur_reg, out_min_reg, out_max_reg;

    // classification of the incoming item
    logic       in_range, frame_end, crc_match;
    kind_t      kind;
    op_t        op_new;

    assign in_range  = (int'(sensor) < SENSOR_COUNT);
    assign frame_end = (mode == MODE_BYTE) && (pos_reg == POS_CRC);
    assign crc_match = (crc_reg == data_byte) && (cpd_reg != '0);

    always_comb
    begin
        kind   = KIND_NONE;
        op_new = OP_NONE;
        if (in_range)
        begin
            if (frame_end)
            begin
                kind   = crc_match ? KIND_CONVERT : KIND_PLAIN;
                op_new = crc_match ? OP_CONVERT : OP_NONE;
            end
            else if (mode inside {MODE_RESET, MODE_ABSENT})
            begin
                kind   = KIND_PLAIN;
                op_new = (mode == MODE_RESET) ? OP_RESET : OP_ABSENT;
            end
        end
    end

    assign stat.kind     = kind;
    assign stat.out_free = !out_valid_reg || out_ready;

    // divider operands: |cpd - cr| * 256 / cpd, sign applied afterwards
    logic signed [BYTE_W:0] diff, diff_abs;
    assign diff     = $signed({1'b0, cpd_reg}) - $signed({1'b0, cnt_rem_reg});
    assign diff_abs = diff[BYTE_W] ? -diff : diff;

    logic [BYTE_W:0] rem_sh;
    logic            rem_ge;
    assign rem_sh = {rem_reg, num_reg[15]};
    assign rem_ge = (rem_sh >= {1'b0, cpd_reg});

    // 8.8 value from the quotient
    logic [15:0]       quot_signed, fixed_val;
    logic [BYTE_W-1:0] whole8;
    assign quot_signed = neg_reg ? (~num_reg + 16'd1) : num_reg;
    assign whole8      = {raw_high_reg[0], raw_low_reg[BYTE_W-1:1]};
    assign fixed_val   = {whole8, 8'h00} - QUARTER_DEG + quot_signed;

    // hundredths (<= 99) to tenths digit by reciprocal multiply
    logic [FP_W-1:0] recip_prod;
    logic [3:0]      tenth_digit;
    assign recip_prod  = {8'd0, fp_reg[FP_W-1:8]} * {7'd0, TENTH_RECIP};
    assign tenth_digit = recip_prod[FP_W-1:RECIP_SHIFT];

    logic [IDX_W-1:0] idx;
    assign idx = IDX_W'(item_sensor_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= '0;
            pos_reg         <= '0;
            raw_low_reg     <= '0;
            raw_high_reg    <= '0;
            cnt_rem_reg     <= '0;
            cpd_reg         <= '0;
            item_sensor_reg <= '0;
            op_reg          <= OP_NONE;
        end
        else if (cmd.accept)
        begin
            item_sensor_reg <= sensor;
            op_reg          <= op_new;
            if (mode == MODE_BYTE)
            begin
                if (pos_reg != POS_CRC)
                begin
                    crc_reg <= crc8_step(crc_reg, data_byte);
                    pos_reg <= pos_reg + 1'b1;
                    case (pos_reg)
                        POS_TEMP_LSB:     raw_low_reg  <= data_byte;
                        POS_TEMP_MSB:     raw_high_reg <= data_byte;
                        POS_COUNT_REMAIN: cnt_rem_reg  <= data_byte;
                        POS_COUNT_PER_C:  cpd_reg      <= data_byte;
                        default:          ;
                    endcase
                end
                else
                begin
                    crc_reg <= '0;
                    pos_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            num_reg <= {diff_abs[BYTE_W-1:0], 8'h00};
            rem_reg <= '0;
            neg_reg <= diff[BYTE_W];
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_ge ? BYTE_W'(rem_sh - {1'b0, cpd_reg}) : rem_sh[BYTE_W-1:0];
            num_reg <= {num_reg[14:0], rem_ge};
        end
        if (cmd.mul)
        begin
            whole10_reg <= TENTHS_W'($signed(fixed_val[15:8])) * TEN_SCALE;
            fp_reg      <= {7'd0, fixed_val[7:0]} * {8'd0, PCT_SCALE};
        end
        if (cmd.sum)
            reading_reg <= whole10_reg + $signed({8'd0, tenth_digit});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SENSOR_COUNT; i++)
            begin
                cur_reg[i] <= '0;
                min_reg[i] <= '0;
                max_reg[i] <= '0;
            end
            pres_reg <= '0;
            ext_reg  <= '0;
        end
        else if (cmd.apply)
        begin
            case (op_reg)
                OP_CONVERT:
                begin
                    cur_reg[idx]  <= reading_reg;
                    pres_reg[idx] <= 1'b1;
                    if (!ext_reg[idx])
                    begin
                        min_reg[idx] <= reading_reg;
                        max_reg[idx] <= reading_reg;
                        ext_reg[idx] <= 1'b1;
                    end
                    else if (reading_reg < min_reg[idx])
                        min_reg[idx] <= reading_reg;
                    else if (reading_reg > max_reg[idx])
                        max_reg[idx] <= reading_reg;
                end
                OP_RESET:
                begin
                    min_reg[idx] <= cur_reg[idx];
                    max_reg[idx] <= cur_reg[idx];
                    ext_reg[idx] <= pres_reg[idx];
                end
                OP_ABSENT:
                begin
                    cur_reg[idx]  <= '0;
                    pres_reg[idx] <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.load_out)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_sensor_reg    <= item_sensor_reg;
            out_ok_reg        <= (op_reg == OP_CONVERT);
            out_cur_reg       <= pres_reg[idx] ? cur_reg[idx] : '0;
            out_cur_valid_reg <= pres_reg[idx];
            out_min_reg       <= min_reg[idx];
            out_max_reg       <= max_reg[idx];
            out_mm_valid_reg  <= ext_reg[idx];
        end
    end

    assign out_valid      = out_valid_reg;
    assign sensor_out     = out_sensor_reg;
    assign crc_ok         = out_ok_reg;
    assign current_tenths = out_cur_reg;
    assign current_valid  = out_cur_valid_reg;
    assign minimum_tenths = out_min_reg;
    assign maximum_tenths = out_max_reg;
    assign minmax_valid   = out_mm_valid_reg;

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_CRC)
        else $error("byte position past the CRC byte");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> out_valid_reg)
        else $error("loaded item not presented");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && frame_end) |=> (pos_reg == '0 && crc_reg == '0))
        else $error("frame state not cleared at ninth byte");

endmodule

@@ bench/tb_scratchpad_temperature_minmax_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for scratchpad_temperature_minmax_top: directed table, then random frames.
// Depends on sptmm_pkg, the sptmm_req_if / sptmm_rsp_if channels and the top-level RTL.
module tb_scratchpad_temperature_minmax_top;
    import sptmm_pkg::*;

    localparam int SENSOR_COUNT  = 3;
    localparam int ITEM_TARGET   = 1900;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 40;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [SENSOR_W-1:0]        sensor;
        logic                       crc_ok;
        logic signed [TENTHS_W-1:0] cur;
        logic                       cur_valid;
        logic signed [TENTHS_W-1:0] lo;
        logic signed [TENTHS_W-1:0] hi;
        logic                       mm_valid;
    } reading_t;

    typedef struct {
        logic [MODE_W-1:0]   mode;
        logic [SENSOR_W-1:0] sensor;
        logic [BYTE_W-1:0]   data;
        bit                  fixed;
        reading_t            want;
    } stim_row_t;

    typedef logic [BYTE_W-1:0] frame_t [9];

    localparam reading_t NO_READING = '0;

    logic clk;
    logic rst_n;

    sptmm_req_if req_ch ();
    sptmm_rsp_if rsp_ch ();

    scratchpad_temperature_minmax_top #(
        .SENSOR_COUNT(SENSOR_COUNT)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Predicted block state
    logic [BYTE_W-1:0]          crc_acc    = '0;
    logic [POS_W-1:0]           frame_pos  = '0;
    logic [BYTE_W-1:0]          temp_lsb   = '0;
    logic [BYTE_W-1:0]          temp_msb   = '0;
    logic [BYTE_W-1:0]          remain_cnt = '0;
    logic [BYTE_W-1:0]          per_c_cnt  = '0;
    logic signed [TENTHS_W-1:0] cur_t  [SENSOR_COUNT] = '{default: '0};
    logic                       cur_ok [SENSOR_COUNT] = '{default: 1'b0};
    logic signed [TENTHS_W-1:0] min_t  [SENSOR_COUNT] = '{default: '0};
    logic signed [TENTHS_W-1:0] max_t  [SENSOR_COUNT] = '{default: '0};
    logic                       ext_ok [SENSOR_COUNT] = '{default: 1'b0};

    reading_t  awaited_readings[$];
    stim_row_t plan[$];
    int        mismatch_count = 0;
    int        items_sent     = 0;
    int        cycle_count    = 0;
    int        send_gap_pct   = 0;
    int        recv_stall_pct = 0;

    function automatic logic [BYTE_W-1:0] crc_next(input logic [BYTE_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] d);
        logic [BYTE_W-1:0] c;
        int b;
        c = crc ^ d;
        for (b = 0; b < 8; b++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [BYTE_W-1:0] frame_crc(input frame_t f);
        logic [BYTE_W-1:0] c;
        int k;
        c = '0;
        for (k = 0; k < 8; k++)
            c = crc_next(c, f[k]);
        return c;
    endfunction

    // Extended-resolution reading in tenths from the latched scratchpad bytes
    function automatic logic signed [TENTHS_W-1:0] to_tenths();
        logic [7:0]  whole8;
        logic [15:0] v;
        int diff;
        int q;
        int whole;
        int frac;
        whole8 = {temp_msb[0], temp_lsb[7:1]};
        diff   = int'(per_c_cnt) - int'(remain_cnt);
        q      = (diff * 256) / int'(per_c_cnt);
        v      = {whole8, 8'h00} - QUARTER_DEG + 16'(q);
        whole  = int'($signed(v[15:8]));
        frac   = int'(v[7:0]);
        return TENTHS_W'(whole * 10 + ((frac * 100) >> 8) / 10);
    endfunction

    function automatic reading_t report(input logic [SENSOR_W-1:0] s, input logic ok);
        reading_t r;
        r.sensor    = s;
        r.crc_ok    = ok;
        r.cur       = cur_ok[s] ? cur_t[s] : '0;
        r.cur_valid = cur_ok[s];
        r.lo        = min_t[s];
        r.hi        = max_t[s];
        r.mm_valid  = ext_ok[s];
        return r;
    endfunction

    function automatic bit step_scratchpad(input logic [MODE_W-1:0] m,
                                           input logic [SENSOR_W-1:0] s,
                                           input logic [BYTE_W-1:0] d,
                                           output reading_t r);
        logic good;
        logic signed [TENTHS_W-1:0] t;
        r = NO_READING;
        if (m == MODE_BYTE) begin
            if (frame_pos < POS_CRC) begin
                crc_acc = crc_next(crc_acc, d);
                case (frame_pos)
                    POS_TEMP_LSB:     temp_lsb   = d;
                    POS_TEMP_MSB:     temp_msb   = d;
                    POS_COUNT_REMAIN: remain_cnt = d;
                    POS_COUNT_PER_C:  per_c_cnt  = d;
                    default: ;
                endcase
                frame_pos = frame_pos + 1'b1;
                return 1'b0;
            end
            // ninth byte closes the frame whatever the sensor index
            good      = (crc_acc == d) && (per_c_cnt != 0);
            crc_acc   = '0;
            frame_pos = '0;
            if (s >= SENSOR_COUNT)
                return 1'b0;
            if (good) begin
                t         = to_tenths();
                cur_t[s]  = t;
                cur_ok[s] = 1'b1;
                if (!ext_ok[s]) begin
                    min_t[s]  = t;
                    max_t[s]  = t;
                    ext_ok[s] = 1'b1;
                end
                else if (t < min_t[s])
                    min_t[s] = t;
                else if (t > max_t[s])
                    max_t[s] = t;
            end
            r = report(s, good);
            return 1'b1;
        end
        if (m == MODE_UNUSED || s >= SENSOR_COUNT)
            return 1'b0;
        if (m == MODE_RESET) begin
            min_t[s]  = cur_t[s];
            max_t[s]  = cur_t[s];
            ext_ok[s] = cur_ok[s];
        end
        else begin
            cur_ok[s] = 1'b0;
            cur_t[s]  = '0;
        end
        r = report(s, 1'b0);
        return 1'b1;
    endfunction

    task automatic add_row(input logic [MODE_W-1:0] m, input logic [SENSOR_W-1:0] s,
                           input logic [BYTE_W-1:0] d, input bit fixed, input reading_t want);
        stim_row_t row;
        row.mode   = m;
        row.sensor = s;
        row.data   = d;
        row.fixed  = fixed;
        row.want   = want;
        plan.push_back(row);
    endtask

    // Called at a falling edge with valid low; returns at a falling edge with valid low.
    task automatic send_item(input logic [MODE_W-1:0] m, input logic [SENSOR_W-1:0] s,
                             input logic [BYTE_W-1:0] d, input bit fixed, input reading_t want);
        reading_t r;
        bit has;
        while ($urandom_range(0, 99) < send_gap_pct)
            @(negedge clk);
        req_ch.valid     = 1'b1;
        req_ch.mode      = m;
        req_ch.sensor    = s;
        req_ch.data_byte = d;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        has = step_scratchpad(m, s, d, r);
        if (has)
            awaited_readings.push_back(fixed ? want : r);
        if (m != MODE_UNUSED)
            items_sent++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    // Hold the sender until every expected item has arrived and the block has settled
    task automatic drain();
        while (awaited_readings.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic set_phase(input int p);
        case (p)
            0: begin send_gap_pct = 10; recv_stall_pct = 57; end
            1: begin send_gap_pct = 57; recv_stall_pct = 10; end
            default: begin send_gap_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    function automatic void check_field(input string name, input int exp, input int got);
        if (exp != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, got);
            mismatch_count++;
        end
    endfunction

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        forever begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial begin
        reading_t want;
        forever begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
                if (awaited_readings.size() == 0) begin
                    $display("%0t: unexpected item for sensor %0d", $time, rsp_ch.sensor_out);
                    mismatch_count++;
                end
                else begin
                    want = awaited_readings.pop_front();
                    check_field("sensor_out", want.sensor, rsp_ch.sensor_out);
                    check_field("crc_ok", want.crc_ok, rsp_ch.crc_ok);
                    check_field("current_tenths", want.cur, rsp_ch.current_tenths);
                    check_field("current_valid", want.cur_valid, rsp_ch.current_valid);
                    check_field("minimum_tenths", want.lo, rsp_ch.minimum_tenths);
                    check_field("maximum_tenths", want.hi, rsp_ch.maximum_tenths);
                    check_field("minmax_valid", want.mm_valid, rsp_ch.minmax_valid);
                end
            end
        end
    end

    initial begin
        frame_t fb;
        reading_t top_reading;
        logic [SENSOR_W-1:0] tgt;
        int pick;
        int cut;
        int poke;
        int k;
        int phase;

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.mode      = MODE_BYTE;
        req_ch.sensor    = '0;
        req_ch.data_byte = '0;
        phase            = 0;
        set_phase(phase);
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table: empty sensors after reset, ignored items, temperature extremes,
        // a mark-absent arriving mid-frame, then min/max reset and absent on a live sensor.
        add_row(MODE_RESET, 2'd0, 8'h00, 1'b1, '{2'd0, 1'b0, 12'sd0, 1'b0, 12'sd0, 12'sd0, 1'b0});
        add_row(MODE_ABSENT, 2'd2, 8'hFF, 1'b1, '{2'd2, 1'b0, 12'sd0, 1'b0, 12'sd0, 12'sd0, 1'b0});
        add_row(MODE_UNUSED, 2'd0, 8'hFF, 1'b0, NO_READING);

        fb = '{8'hFE, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00};
        fb[8] = frame_crc(fb);
        top_reading = '{2'd0, 1'b1, 12'sd1277, 1'b1, 12'sd1277, 12'sd1277, 1'b1};
        for (k = 0; k < 9; k++)
            add_row(MODE_BYTE, 2'd0, fb[k], k == 8, top_reading);

        fb = '{8'h00, 8'h01, 8'h00, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h01, 8'h00};
        fb[8] = frame_crc(fb);
        for (k = 0; k < 9; k++) begin
            if (k == 4)
                add_row(MODE_ABSENT, 2'd1, 8'h5A, 1'b0, NO_READING);
            add_row(MODE_BYTE, 2'd0, fb[k], 1'b0, NO_READING);
        end
        add_row(MODE_RESET, 2'd0, 8'hA5, 1'b0, NO_READING);
        add_row(MODE_ABSENT, 2'd0, 8'h00, 1'b0, NO_READING);
        add_row(MODE_RESET, 2'd3, 8'h00, 1'b0, NO_READING);

        foreach (plan[i])
            send_item(plan[i].mode, plan[i].sensor, plan[i].data, plan[i].fixed, plan[i].want);
        drain();

        // Random part: mostly whole frames with random content, plus noise and broken frames
        while (items_sent < ITEM_TARGET) begin
            if (items_sent * 3 / ITEM_TARGET > phase) begin
                drain();
                phase++;
                set_phase(phase);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_item(MODE_W'($urandom_range(0, 3)), SENSOR_W'($urandom_range(0, 3)),
                          BYTE_W'($urandom), 1'b0, NO_READING);
            end
            else if (pick < 16) begin
                send_item(MODE_W'($urandom_range(1, 2)), SENSOR_W'($urandom_range(0, 3)),
                          BYTE_W'($urandom), 1'b0, NO_READING);
            end
            else begin
                for (k = 0; k < 6; k++)
                    fb[k] = BYTE_W'($urandom);
                fb[7] = ($urandom_range(0, 99) < 6) ? 8'h00 : BYTE_W'($urandom_range(1, 255));
                fb[6] = ($urandom_range(0, 99) < 70) ? BYTE_W'($urandom_range(0, int'(fb[7])))
                                                     : BYTE_W'($urandom);
                fb[8] = frame_crc(fb);
                if ($urandom_range(0, 99) < 10)
                    fb[8] = fb[8] ^ BYTE_W'($urandom_range(1, 255));
                tgt  = ($urandom_range(0, 99) < 10) ? 2'd3 : SENSOR_W'($urandom_range(0, 2));
                cut  = ($urandom_range(0, 99) < 4) ? $urandom_range(1, 8) : 9;
                poke = ($urandom_range(0, 99) < 8) ? $urandom_range(0, 8) : 99;
                for (k = 0; k < cut; k++) begin
                    if (k == poke)
                        send_item(MODE_W'($urandom_range(1, 3)), SENSOR_W'($urandom_range(0, 3)),
                                  BYTE_W'($urandom), 1'b0, NO_READING);
                    send_item(MODE_BYTE, (k == 8) ? tgt : SENSOR_W'($urandom_range(0, 3)),
                              fb[k], 1'b0, NO_READING);
                end
            end
        end

        drain();
        if (awaited_readings.size() != 0) begin
            $display("%0t: %0d expected items never arrived", $time, awaited_readings.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
